FILE: rtl/i2crts_pkg.sv
// Package: shared types and codes of the I2C register transaction sequencer.
package i2crts_pkg;

  localparam int unsigned MODE_W = 3;
  localparam int unsigned ADDR_W = 7;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ACT_W  = 3;

  // Input item modes.
  localparam logic [MODE_W-1:0] MODE_ENQ_RD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ENQ_WR = 3'd1;
  localparam logic [MODE_W-1:0] MODE_KICK   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EVENT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ERROR  = 3'd4;

  // Bus actions on the result side.
  localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_START = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SEND  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_STOP  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ  = 3'd4;

  // Classified command handed from front to back.
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_ENQ,
    CMD_KICK,
    CMD_EVENT,
    CMD_ERROR
  } cmd_e;

  // One queued register request (24 bits).
  typedef struct packed {
    logic              is_write;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] reg_idx;
    logic [ADDR_W-1:0] addr;
  } req_t;

  typedef struct packed {
    cmd_e              op;
    req_t              req;
    logic [BYTE_W-1:0] rx;
  } cmd_t;

endpackage

FILE: rtl/i2crts_if.sv
// Interfaces: input item channel and result channel with valid/ready.
interface i2crts_in_if;
  logic                           valid;
  logic                           ready;
  logic [i2crts_pkg::MODE_W-1:0]  mode;
  logic [i2crts_pkg::ADDR_W-1:0]  address;
  logic [i2crts_pkg::BYTE_W-1:0]  reg_req;
  logic [i2crts_pkg::BYTE_W-1:0]  data;
  logic [i2crts_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, mode, address, reg_req, data, rx_byte, input ready);
  modport sink   (input valid, mode, address, reg_req, data, rx_byte, output ready);
endinterface

interface i2crts_out_if;
  logic                           valid;
  logic                           ready;
  logic [i2crts_pkg::ACT_W-1:0]   action;
  logic [i2crts_pkg::BYTE_W-1:0]  byte_res;
  logic                           accepted;
  logic                           all_done;

  modport source (output valid, action, byte_res, accepted, all_done, input ready);
  modport sink   (input valid, action, byte_res, accepted, all_done, output ready);
endinterface

FILE: rtl/i2crts_front.sv
// Front end: classifies input transfers and buffers them in a two-entry command queue.
module i2crts_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  i2crts_in_if.sink         in_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output i2crts_pkg::cmd_t  cmd_o
);

  i2crts_pkg::cmd_t cmd_mem_q [2];
  i2crts_pkg::cmd_t cls;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  // Decode the mode into a command; unknown modes become a no-op.
  always_comb begin
    cls.op          = i2crts_pkg::CMD_NOP;
    cls.req.addr    = in_i.address;
    cls.req.reg_idx = in_i.reg_req;
    cls.req.data    = '0;
    cls.req.is_write = 1'b0;
    cls.rx          = in_i.rx_byte;
    case (in_i.mode)
      i2crts_pkg::MODE_ENQ_RD: begin
        cls.op = i2crts_pkg::CMD_ENQ;
      end
      i2crts_pkg::MODE_ENQ_WR: begin
        cls.op           = i2crts_pkg::CMD_ENQ;
        cls.req.data     = in_i.data;
        cls.req.is_write = 1'b1;
      end
      i2crts_pkg::MODE_KICK:  cls.op = i2crts_pkg::CMD_KICK;
      i2crts_pkg::MODE_EVENT: cls.op = i2crts_pkg::CMD_EVENT;
      i2crts_pkg::MODE_ERROR: cls.op = i2crts_pkg::CMD_ERROR;
      default:                cls.op = i2crts_pkg::CMD_NOP;
    endcase
  end

  assign in_i.ready  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = cmd_mem_q[rd_ptr_q];
  assign push        = in_i.valid && in_i.ready;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

FILE: rtl/i2crts_back.sv
// Back end: request ring buffer, bus sequencer and registered result stage.
module i2crts_back #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  i2crts_pkg::cmd_t  cmd_i,
  i2crts_out_if.source      out_o
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_C  = PW'(QUEUE_DEPTH - 1);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_ADDR_W  = 4'd1;
  localparam logic [3:0] ST_REG     = 4'd2;
  localparam logic [3:0] ST_DATA    = 4'd3;
  localparam logic [3:0] ST_RESTART = 4'd4;
  localparam logic [3:0] ST_ADDR_R  = 4'd5;
  localparam logic [3:0] ST_RECV    = 4'd6;
  localparam logic [3:0] ST_STOP    = 4'd7;
  localparam logic [3:0] ST_DONE    = 4'd8;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LAST_C) ? '0 : p + 1'b1;
  endfunction

  i2crts_pkg::req_t mem [QUEUE_DEPTH];
  i2crts_pkg::req_t cur_q;

  logic [PW-1:0] head_q, head_d, tail_q, tail_d, load_ptr;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [3:0]    st_q, st_d;
  logic          fire, we, load;

  logic                          out_valid_q, out_valid_d;
  logic [i2crts_pkg::ACT_W-1:0]  act_d, act_q;
  logic [i2crts_pkg::BYTE_W-1:0] byte_d, byte_q;
  logic                          acc_d, acc_q, done_d, done_q;

  assign cmd_ready_o = !out_valid_q || out_o.ready;
  assign fire        = cmd_valid_i && cmd_ready_o;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    st_d     = st_q;
    we       = 1'b0;
    load     = 1'b0;
    load_ptr = head_q;
    act_d    = i2crts_pkg::ACT_NONE;
    byte_d   = '0;
    acc_d    = 1'b0;
    done_d   = 1'b0;
    if (fire) begin
      case (cmd_i.op)
        i2crts_pkg::CMD_ENQ: begin
          if (cnt_q < DEPTH_C) begin
            we     = 1'b1;
            tail_d = ptr_inc(tail_q);
            cnt_d  = cnt_q + 1'b1;
            acc_d  = 1'b1;
          end
        end
        i2crts_pkg::CMD_KICK: begin
          if (st_q == ST_IDLE && cnt_q != '0) begin
            load  = 1'b1;
            st_d  = ST_ADDR_W;
            act_d = i2crts_pkg::ACT_START;
          end
        end
        i2crts_pkg::CMD_EVENT: begin
          case (st_q)
            ST_ADDR_W: begin
              act_d  = i2crts_pkg::ACT_SEND;
              byte_d = {cur_q.addr, 1'b0};
              st_d   = ST_REG;
            end
            ST_REG: begin
              act_d  = i2crts_pkg::ACT_SEND;
              byte_d = cur_q.reg_idx;
              st_d   = cur_q.is_write ? ST_DATA : ST_RESTART;
            end
            ST_DATA: begin
              act_d  = i2crts_pkg::ACT_SEND;
              byte_d = cur_q.data;
              st_d   = ST_STOP;
            end
            ST_RESTART: begin
              act_d = i2crts_pkg::ACT_START;
              st_d  = ST_ADDR_R;
            end
            ST_ADDR_R: begin
              act_d  = i2crts_pkg::ACT_SEND;
              byte_d = {cur_q.addr, 1'b1};
              st_d   = ST_RECV;
            end
            ST_RECV: begin
              act_d  = i2crts_pkg::ACT_READ;
              byte_d = cmd_i.rx;
              st_d   = ST_STOP;
            end
            ST_STOP: begin
              act_d = i2crts_pkg::ACT_STOP;
              st_d  = ST_DONE;
            end
            ST_DONE: begin
              // retire head, then chain into the next request if any
              if (cnt_q != '0) begin
                head_d = ptr_inc(head_q);
                cnt_d  = cnt_q - 1'b1;
              end
              if (cnt_d != '0) begin
                load     = 1'b1;
                load_ptr = head_d;
                st_d     = ST_ADDR_W;
                act_d    = i2crts_pkg::ACT_START;
              end else begin
                st_d   = ST_IDLE;
                done_d = 1'b1;
              end
            end
            default: st_d = ST_IDLE;
          endcase
        end
        i2crts_pkg::CMD_ERROR: act_d = i2crts_pkg::ACT_STOP;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Single write port at tail, single read port at the head being loaded.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[tail_q] <= cmd_i.req;
    end
    if (load) begin
      cur_q <= mem[load_ptr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      act_q  <= act_d;
      byte_q <= byte_d;
      acc_q  <= acc_d;
      done_q <= done_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.action   = act_q;
  assign out_o.byte_res = byte_q;
  assign out_o.accepted = acc_q;
  assign out_o.all_done = done_q;

endmodule

FILE: rtl/i2c_register_transaction_sequencer_unit.sv
// Top level: I2C register transaction sequencer (front classifier + back sequencer).
// Path: an input transfer passes the command queue, then the result register, before its result is offered.
// Throughput: while out_o.ready stays high, one transfer per cycle is sustained and the back end
//   retires one command per cycle through one sequencer step and one request-queue memory port.
// Reset: rst_ni is asynchronous, active low; it empties both queues and idles the sequencer.
//   Request-queue entries are not cleared; only written entries are ever read.
module i2c_register_transaction_sequencer_unit #(
  parameter int unsigned QUEUE_DEPTH = 8   // request ring depth, 2..64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2crts_in_if.sink     in_i,
  i2crts_out_if.source  out_o
);

  // Classified commands flow from the front to the back through a
  // two-entry queue so input and output stalls do not couple.
  logic             cmd_valid;
  logic             cmd_ready;
  i2crts_pkg::cmd_t cmd;

  i2crts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Back end owns the request ring, the bus sequencer and the result register.
  i2crts_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_o       (out_o)
  );

  // A full command queue always has a command pending for the back end.
  a_full_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> cmd_valid)
    else $error("command queue full but nothing offered to back end");

  // A stored enqueue never carries a bus action.
  a_acc_no_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.accepted |-> out_o.action == i2crts_pkg::ACT_NONE)
    else $error("enqueue result carries a bus action");

  // The all-done flag comes alone, with no action and no enqueue.
  a_done_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.all_done |->
      out_o.action == i2crts_pkg::ACT_NONE && !out_o.accepted)
    else $error("all_done raised together with other result bits");

  // Only send and read results carry a byte.
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.action == i2crts_pkg::ACT_NONE ||
                    out_o.action == i2crts_pkg::ACT_START ||
                    out_o.action == i2crts_pkg::ACT_STOP) |-> out_o.byte_res == '0)
    else $error("byte on a result without a byte");

endmodule

FILE: test/tb_i2c_register_transaction_sequencer_unit.sv
// Testbench: self-checking stimulus and bus-action prediction for the I2C register sequencer.
module tb_i2c_register_transaction_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // Run knobs
  // ---------------------------------------------------------------------------
  localparam int unsigned RING_DEPTH   = 8;       // matches the DUT parameter below
  localparam int unsigned RANDOM_ITEMS = 1725;    // random items after the directed rows
  localparam int unsigned HOLD_AT      = 400;     // transfers in before the long output stall
  localparam int unsigned HOLD_CYCLES  = 300;     // length of that stall
  localparam int unsigned DRAIN_CYCLES = 10;      // slack after the last expected result
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned REPORT_MAX   = 10;

  // Mode 7 is not decoded by the block; it must pass through as a no-op.
  localparam logic [i2crts_pkg::MODE_W-1:0] MODE_RSVD = 3'd7;

  // Short names for the directed table.
  localparam logic [i2crts_pkg::MODE_W-1:0] M_RD   = i2crts_pkg::MODE_ENQ_RD;
  localparam logic [i2crts_pkg::MODE_W-1:0] M_WR   = i2crts_pkg::MODE_ENQ_WR;
  localparam logic [i2crts_pkg::MODE_W-1:0] M_KICK = i2crts_pkg::MODE_KICK;
  localparam logic [i2crts_pkg::MODE_W-1:0] M_EVT  = i2crts_pkg::MODE_EVENT;
  localparam logic [i2crts_pkg::MODE_W-1:0] M_ERR  = i2crts_pkg::MODE_ERROR;
  localparam logic [i2crts_pkg::ACT_W-1:0]  A_NONE  = i2crts_pkg::ACT_NONE;
  localparam logic [i2crts_pkg::ACT_W-1:0]  A_START = i2crts_pkg::ACT_START;
  localparam logic [i2crts_pkg::ACT_W-1:0]  A_SEND  = i2crts_pkg::ACT_SEND;
  localparam logic [i2crts_pkg::ACT_W-1:0]  A_STOP  = i2crts_pkg::ACT_STOP;
  localparam logic [i2crts_pkg::ACT_W-1:0]  A_READ  = i2crts_pkg::ACT_READ;

  // Bus sequence position, kept locally for prediction only.
  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_ADDR_W, SEQ_REG, SEQ_DATA, SEQ_RESTART,
    SEQ_ADDR_R, SEQ_RECV, SEQ_STOP, SEQ_DONE
  } seq_state_e;

  // Output stall styles of the result receiver.
  typedef enum int unsigned {RX_ALWAYS, RX_MOSTLY, RX_PATTERN, RX_SPARSE} rx_style_e;

  typedef struct packed {
    logic [i2crts_pkg::ACT_W-1:0]  action;
    logic [i2crts_pkg::BYTE_W-1:0] data_byte;
    logic                          accepted;
    logic                          all_done;
  } bus_result_t;

  // One input transfer; typed rows carry a hand-written expected result.
  typedef struct {
    logic [i2crts_pkg::MODE_W-1:0] mode;
    logic [i2crts_pkg::ADDR_W-1:0] addr;
    logic [i2crts_pkg::BYTE_W-1:0] reg_idx;
    logic [i2crts_pkg::BYTE_W-1:0] wdata;
    logic [i2crts_pkg::BYTE_W-1:0] rx;
    bit                            typed;
    bus_result_t                   want;
  } bus_cmd_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // ---------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Single reset at the start; deasserted on a clock edge.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  i2crts_in_if  in_if ();
  i2crts_out_if out_if ();

  i2c_register_transaction_sequencer_unit #(
    .QUEUE_DEPTH(RING_DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: request ring, sequence position, active request
  // ---------------------------------------------------------------------------
  i2crts_pkg::req_t req_ring [RING_DEPTH];
  int unsigned      ring_head  = 0;
  int unsigned      ring_tail  = 0;
  int unsigned      ring_count = 0;
  seq_state_e       seq_state  = SEQ_IDLE;
  i2crts_pkg::req_t active_req = '0;

  bus_result_t pending_actions[$];   // predicted results, oldest first
  bus_cmd_t    cmd_plan[$];          // directed table

  // Stimulus shaping: fill phases grow the ring, drain phases run it dry.
  bit          fill_phase = 1'b1;
  int unsigned phase_left = 0;

  // Bookkeeping
  int unsigned cycles        = 0;
  int unsigned items_taken   = 0;
  int unsigned random_taken  = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned reqs_retired  = 0;
  int unsigned done_flags    = 0;
  int unsigned enq_dropped   = 0;
  int unsigned bytes_read    = 0;
  bit          stim_finished = 1'b0;

  // Advance the local copy of the sequencer by one accepted transfer and
  // return the bus action it must produce.
  function automatic bus_result_t next_bus_action(input bus_cmd_t c);
    bus_result_t      r;
    i2crts_pkg::req_t cur;
    i2crts_pkg::req_t entry;
    r   = '0;
    cur = active_req;
    case (c.mode)
      i2crts_pkg::MODE_ENQ_RD, i2crts_pkg::MODE_ENQ_WR: begin
        if (ring_count < RING_DEPTH) begin
          entry.is_write = (c.mode == i2crts_pkg::MODE_ENQ_WR);
          entry.data     = entry.is_write ? c.wdata : '0;
          entry.reg_idx  = c.reg_idx;
          entry.addr     = c.addr;
          req_ring[ring_tail] = entry;
          ring_tail  = (ring_tail + 1) % RING_DEPTH;
          ring_count++;
          r.accepted = 1'b1;
        end else begin
          enq_dropped++;
        end
      end
      i2crts_pkg::MODE_KICK: begin
        // only an idle sequencer with work queued reacts
        if (seq_state == SEQ_IDLE && ring_count > 0) begin
          active_req = req_ring[ring_head];
          seq_state  = SEQ_ADDR_W;
          r.action   = i2crts_pkg::ACT_START;
        end
      end
      i2crts_pkg::MODE_EVENT: begin
        case (seq_state)
          SEQ_ADDR_W: begin
            r.action    = i2crts_pkg::ACT_SEND;
            r.data_byte = {cur.addr, 1'b0};
            seq_state   = SEQ_REG;
          end
          SEQ_REG: begin
            r.action    = i2crts_pkg::ACT_SEND;
            r.data_byte = cur.reg_idx;
            seq_state   = cur.is_write ? SEQ_DATA : SEQ_RESTART;
          end
          SEQ_DATA: begin
            r.action    = i2crts_pkg::ACT_SEND;
            r.data_byte = cur.data;
            seq_state   = SEQ_STOP;
          end
          SEQ_RESTART: begin
            r.action  = i2crts_pkg::ACT_START;
            seq_state = SEQ_ADDR_R;
          end
          SEQ_ADDR_R: begin
            r.action    = i2crts_pkg::ACT_SEND;
            r.data_byte = {cur.addr, 1'b1};
            seq_state   = SEQ_RECV;
          end
          SEQ_RECV: begin
            r.action    = i2crts_pkg::ACT_READ;
            r.data_byte = c.rx;
            seq_state   = SEQ_STOP;
            bytes_read++;
          end
          SEQ_STOP: begin
            r.action  = i2crts_pkg::ACT_STOP;
            seq_state = SEQ_DONE;
          end
          SEQ_DONE: begin
            // retire head, then chain into the next request or finish
            if (ring_count > 0) begin
              ring_head = (ring_head + 1) % RING_DEPTH;
              ring_count--;
              reqs_retired++;
            end
            if (ring_count > 0) begin
              active_req = req_ring[ring_head];
              seq_state  = SEQ_ADDR_W;
              r.action   = i2crts_pkg::ACT_START;
            end else begin
              seq_state  = SEQ_IDLE;
              r.all_done = 1'b1;
              done_flags++;
            end
          end
          default: seq_state = SEQ_IDLE;
        endcase
      end
      i2crts_pkg::MODE_ERROR: r.action = i2crts_pkg::ACT_STOP;   // stop only, position kept
      default: ;
    endcase
    return r;
  endfunction

  // Random transfer, biased toward well-formed sequences using the predicted
  // state; a share of noise covers every mode, reserved codes included.
  function automatic bus_cmd_t random_cmd();
    bus_cmd_t    c;
    int unsigned roll;
    c.addr    = 7'($urandom_range(0, 127));
    c.reg_idx = 8'($urandom_range(0, 255));
    c.wdata   = 8'($urandom_range(0, 255));
    c.rx      = 8'($urandom_range(0, 255));
    c.typed   = 1'b0;
    c.want    = '0;
    if (phase_left == 0) begin
      fill_phase = 1'($urandom_range(0, 1));
      phase_left = $urandom_range(30, 150);
    end
    phase_left--;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      c.mode = 3'($urandom_range(0, 7));
    end else if (seq_state == SEQ_IDLE) begin
      if (ring_count == 0 || (fill_phase && roll < 50))
        c.mode = $urandom_range(0, 1) ? i2crts_pkg::MODE_ENQ_WR : i2crts_pkg::MODE_ENQ_RD;
      else
        c.mode = i2crts_pkg::MODE_KICK;
    end else if (fill_phase && roll < 30) begin
      c.mode = $urandom_range(0, 1) ? i2crts_pkg::MODE_ENQ_WR : i2crts_pkg::MODE_ENQ_RD;
    end else if (roll < 33) begin
      c.mode = i2crts_pkg::MODE_ERROR;
    end else if (roll < 35) begin
      c.mode = i2crts_pkg::MODE_KICK;
    end else begin
      c.mode = i2crts_pkg::MODE_EVENT;
    end
    return c;
  endfunction

  task automatic row(input logic [i2crts_pkg::MODE_W-1:0] mode,
                     input logic [i2crts_pkg::ADDR_W-1:0] addr,
                     input logic [i2crts_pkg::BYTE_W-1:0] reg_idx,
                     input logic [i2crts_pkg::BYTE_W-1:0] wdata,
                     input logic [i2crts_pkg::BYTE_W-1:0] rx, input bit typed,
                     input logic [i2crts_pkg::ACT_W-1:0] act,
                     input logic [i2crts_pkg::BYTE_W-1:0] b,
                     input logic acc, input logic done);
    bus_cmd_t c;
    c.mode    = mode;
    c.addr    = addr;
    c.reg_idx = reg_idx;
    c.wdata   = wdata;
    c.rx      = rx;
    c.typed   = typed;
    c.want    = '{action: act, data_byte: b, accepted: acc, all_done: done};
    cmd_plan.push_back(c);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: idle corner cases, ring fill to overflow, then one full
  // write and one full read with a bus error dropped into the write.
  // ---------------------------------------------------------------------------
  initial begin
    //   mode       addr   reg    data   rx    typ act      byte   acc  done
    row(M_EVT,     7'h00, 8'h00, 8'h00, 8'h00, 1, A_NONE,  8'h00, 1'b0, 1'b0); // idle event
    row(M_KICK,    7'h00, 8'h00, 8'h00, 8'h00, 1, A_NONE,  8'h00, 1'b0, 1'b0); // kick, empty
    row(MODE_RSVD, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1, A_NONE,  8'h00, 1'b0, 1'b0); // unknown mode
    row(M_WR,      7'h7F, 8'hFF, 8'hFF, 8'h00, 1, A_NONE,  8'h00, 1'b1, 1'b0);
    row(M_RD,      7'h00, 8'h00, 8'hFF, 8'hFF, 1, A_NONE,  8'h00, 1'b1, 1'b0);
    row(M_WR,      7'h55, 8'h0F, 8'hF0, 8'h00, 1, A_NONE,  8'h00, 1'b1, 1'b0);
    row(M_RD,      7'h2A, 8'hC3, 8'h00, 8'h00, 1, A_NONE,  8'h00, 1'b1, 1'b0);
    row(M_WR,      7'h01, 8'h80, 8'h01, 8'h00, 1, A_NONE,  8'h00, 1'b1, 1'b0);
    row(M_RD,      7'h40, 8'h01, 8'h00, 8'h00, 1, A_NONE,  8'h00, 1'b1, 1'b0);
    row(M_WR,      7'h33, 8'h5A, 8'hA5, 8'h00, 1, A_NONE,  8'h00, 1'b1, 1'b0);
    row(M_RD,      7'h4C, 8'h7E, 8'h00, 8'h00, 1, A_NONE,  8'h00, 1'b1, 1'b0);
    row(M_WR,      7'h11, 8'h22, 8'h33, 8'h00, 1, A_NONE,  8'h00, 1'b0, 1'b0); // ring full
    row(M_KICK,    7'h00, 8'h00, 8'h00, 8'h00, 1, A_START, 8'h00, 1'b0, 1'b0);
    row(M_KICK,    7'h00, 8'h00, 8'h00, 8'h00, 1, A_NONE,  8'h00, 1'b0, 1'b0); // busy kick
    row(M_EVT,     7'h00, 8'h00, 8'h00, 8'h00, 1, A_SEND,  8'hFE, 1'b0, 1'b0); // addr+W
    row(M_EVT,     7'h00, 8'h00, 8'h00, 8'h00, 1, A_SEND,  8'hFF, 1'b0, 1'b0); // register
    row(M_ERR,     7'h00, 8'h00, 8'h00, 8'h00, 1, A_STOP,  8'h00, 1'b0, 1'b0); // bus error
    row(M_EVT,     7'h00, 8'h00, 8'h00, 8'h00, 1, A_SEND,  8'hFF, 1'b0, 1'b0); // data
    row(M_EVT,     7'h00, 8'h00, 8'h00, 8'h00, 1, A_STOP,  8'h00, 1'b0, 1'b0);
    row(M_EVT,     7'h00, 8'h00, 8'h00, 8'h00, 1, A_START, 8'h00, 1'b0, 1'b0); // next head
    row(M_EVT,     7'h00, 8'h00, 8'h00, 8'h00, 1, A_SEND,  8'h00, 1'b0, 1'b0); // addr+W
    row(M_EVT,     7'h00, 8'h00, 8'h00, 8'h00, 1, A_SEND,  8'h00, 1'b0, 1'b0); // register
    row(M_EVT,     7'h00, 8'h00, 8'h00, 8'h00, 1, A_START, 8'h00, 1'b0, 1'b0); // rep. start
    row(M_EVT,     7'h00, 8'h00, 8'h00, 8'h00, 1, A_SEND,  8'h01, 1'b0, 1'b0); // addr+R
    row(M_EVT,     7'h00, 8'h00, 8'h00, 8'hA5, 1, A_READ,  8'hA5, 1'b0, 1'b0); // rx byte
    row(M_EVT,     7'h00, 8'h00, 8'h00, 8'h00, 1, A_STOP,  8'h00, 1'b0, 1'b0);
  end

  // ---------------------------------------------------------------------------
  // Input side: bursts of transfers separated by random gaps. Every transfer is
  // fed to the predictor the moment it is taken.
  // ---------------------------------------------------------------------------
  initial begin : item_source
    bus_cmd_t    c;
    bus_result_t got;
    int unsigned plan_idx;
    int unsigned burst_left;
    int unsigned gap;
    plan_idx   = 0;
    burst_left = 0;
    in_if.valid   = 1'b0;
    in_if.mode    = '0;
    in_if.address = '0;
    in_if.reg_req = '0;
    in_if.data    = '0;
    in_if.rx_byte = '0;
    @(posedge rst_ni);
    @(posedge clk_i);
    while (plan_idx < cmd_plan.size() || random_taken < RANDOM_ITEMS) begin
      if (plan_idx < cmd_plan.size()) begin
        c = cmd_plan[plan_idx];
        plan_idx++;
      end else begin
        c = random_cmd();
      end
      if (burst_left == 0) begin
        // a quarter of bursts follow the previous one back to back, with no gap
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        burst_left = $urandom_range(1, 40);
        if (gap != 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
      in_if.valid   <= 1'b1;
      in_if.mode    <= c.mode;
      in_if.address <= c.addr;
      in_if.reg_req <= c.reg_idx;
      in_if.data    <= c.wdata;
      in_if.rx_byte <= c.rx;
      @(posedge clk_i);
      while (!in_if.ready) @(posedge clk_i);
      // transfer taken at this edge
      got = next_bus_action(c);
      pending_actions.push_back(c.typed ? c.want : got);
      items_taken++;
      if (plan_idx >= cmd_plan.size() && !c.typed)
        random_taken++;
    end
    in_if.valid <= 1'b0;
    stim_finished = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Output side: ready follows a random style, redrawn when its run ends,
  // plus one long hold-off so the block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    rx_style_e   style;
    int unsigned left;
    bit          held;
    style = RX_ALWAYS;
    left  = 0;
    held  = 1'b0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && items_taken >= HOLD_AT) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        if (left == 0) begin
          style = rx_style_e'($urandom_range(0, 3));
          left  = $urandom_range(16, 160);
        end
        left--;
        case (style)
          RX_ALWAYS:  out_if.ready <= 1'b1;
          RX_MOSTLY:  out_if.ready <= ($urandom_range(0, 99) < 70);
          RX_PATTERN: out_if.ready <= ((left % 4) != 0);
          default:    out_if.ready <= ($urandom_range(0, 99) < 25);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each transfer out is matched against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic log_failure(input string what);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("[%0t] ERROR: %s", $realtime, what);
  endtask

  always @(posedge clk_i) begin
    bus_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_actions.size() == 0) begin
        log_failure($sformatf("unexpected result act=%0d byte=%02h acc=%0b done=%0b",
                              out_if.action, out_if.byte_res, out_if.accepted,
                              out_if.all_done));
      end else begin
        want = pending_actions.pop_front();
        if (out_if.action !== want.action || out_if.byte_res !== want.data_byte ||
            out_if.accepted !== want.accepted || out_if.all_done !== want.all_done)
          log_failure({$sformatf("result %0d: want act=%0d byte=%02h acc=%0b done=%0b, ",
                                 results_seen, want.action, want.data_byte,
                                 want.accepted, want.all_done),
                       $sformatf("got act=%0d byte=%02h acc=%0b done=%0b",
                                 out_if.action, out_if.byte_res, out_if.accepted,
                                 out_if.all_done)});
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_actions.size());
      $display("i2c_register_transaction_sequencer_unit test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // End of run: drain outstanding results, allow stray ones to show, report.
  // ---------------------------------------------------------------------------
  initial begin : wrap_up
    wait (stim_finished);
    while (pending_actions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d transfers in (%0d directed), %0d results checked, %0d failures",
             items_taken, cmd_plan.size(), results_seen, mismatches);
    $display("%0d requests retired, %0d bytes read, %0d all-done, %0d enqueues dropped",
             reqs_retired, bytes_read, done_flags, enq_dropped);
    if (mismatches == 0)
      $display("i2c_register_transaction_sequencer_unit test passed");
    else
      $display("i2c_register_transaction_sequencer_unit test failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/i2crts_pkg.sv
rtl/i2crts_if.sv
rtl/i2crts_front.sv
rtl/i2crts_back.sv
rtl/i2c_register_transaction_sequencer_unit.sv
test/tb_i2c_register_transaction_sequencer_unit.sv
